>>> sv/cbam_pkg.sv
// Shared types and constants for the cartridge bank address map.
`timescale 1ns / 1ps

package cbam_pkg;

    localparam int CART_ADDR_BITS_DEF = 21;
    localparam int CART_OUT_BITS      = 21;
    localparam int ADDR_BITS          = 16;
    localparam int DATA_BITS          = 8;
    localparam int OFFSET_BITS        = 13;

    // Bank controller kinds held in the mapper register.
    typedef enum logic [1:0] {
        MAP_NONE = 2'd0,
        MAP_MBC1 = 2'd1,
        MAP_MBC2 = 2'd2,
        MAP_MBC3 = 2'd3
    } t_mapper;

    // Region codes of one access.
    typedef enum logic [3:0] {
        RGN_ROM0     = 4'd0,
        RGN_ROMX     = 4'd1,
        RGN_VRAM     = 4'd2,
        RGN_ERAM     = 4'd3,
        RGN_WRAM     = 4'd4,
        RGN_OAM      = 4'd5,
        RGN_UNUSABLE = 4'd6,
        RGN_IO       = 4'd7,
        RGN_HRAM     = 4'd8,
        RGN_IE       = 4'd9,
        RGN_CTRL     = 4'd10
    } t_region;

    // Mapper control areas, address bits 14:13.
    typedef enum logic [1:0] {
        AREA_RAM_EN = 2'd0,
        AREA_ROM_LO = 2'd1,
        AREA_UPPER  = 2'd2,
        AREA_MODE   = 2'd3
    } t_area;

    localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
    localparam logic [15:0] OAM_END      = 16'hFEA0;
    localparam logic [15:0] IO_LAST      = 16'hFF7F;
    localparam logic [15:0] HRAM_LAST    = 16'hFFFE;

    // Configuration register word index.
    localparam logic CFG_MAPPER = 1'b0;

    typedef struct packed {
        logic [7:0] rom_bank;
        logic [1:0] ram_bank;
        logic       ram_enable;
        logic       mode_16_8;
    } t_bank_state;

    localparam t_bank_state BANK_RESET = '{
        rom_bank:   8'd1,
        ram_bank:   2'd0,
        ram_enable: 1'b0,
        mode_16_8:  1'b1
    };

    typedef struct packed {
        logic       func;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
    } t_request;

    typedef struct packed {
        t_region     region;
        logic [20:0] cart_address;
        logic [12:0] local_offset;
        logic [1:0]  ext_ram_bank;
        logic        ext_ram_enabled;
    } t_result;

endpackage

>>> sv/cbam_map.sv
// Address decode and bank controller next-state logic for one request.
`timescale 1ns / 1ps

module cbam_map #(
    parameter int CART_ADDR_BITS = cbam_pkg::CART_ADDR_BITS_DEF
) (
    input  cbam_pkg::t_mapper     i_mapper,
    input  cbam_pkg::t_bank_state i_state,
    input  cbam_pkg::t_request    i_req,
    output cbam_pkg::t_bank_state o_state,
    output cbam_pkg::t_result     o_res
);

    localparam int EFF_BITS = (CART_ADDR_BITS < cbam_pkg::CART_OUT_BITS) ?
                              CART_ADDR_BITS : cbam_pkg::CART_OUT_BITS;

    logic [15:0]          addr;
    logic [7:0]           v;
    logic                 bit8;
    cbam_pkg::t_area      area;
    logic [21:0]          raw_cart;
    logic [20:0]          cart;
    logic [4:0]           lo5;
    logic [3:0]           lo4;
    logic [6:0]           lo7;
    cbam_pkg::t_bank_state nxt;

    assign addr = i_req.bus_address;
    assign v    = i_req.write_value;
    assign bit8 = addr[8];
    assign area = cbam_pkg::t_area'(addr[14:13]);
    assign lo5  = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
    assign lo4  = (v[3:0] == 4'd0) ? 4'd1 : v[3:0];
    assign lo7  = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];

    // Control writes.
    always_comb begin
        nxt = i_state;
        if (i_req.func && !addr[15] && i_mapper != cbam_pkg::MAP_NONE) begin
            case (area)
                cbam_pkg::AREA_RAM_EN: begin
                    if (!(i_mapper == cbam_pkg::MAP_MBC2 && bit8)) begin
                        nxt.ram_enable = (v[3:0] == cbam_pkg::RAM_EN_KEY);
                    end
                end
                cbam_pkg::AREA_ROM_LO: begin
                    case (i_mapper)
                        cbam_pkg::MAP_MBC1: nxt.rom_bank = {i_state.rom_bank[7:5], lo5};
                        cbam_pkg::MAP_MBC2: begin
                            if (bit8) begin
                                nxt.rom_bank = {4'd0, lo4};
                            end
                        end
                        default: nxt.rom_bank = {1'b0, lo7};
                    endcase
                end
                cbam_pkg::AREA_UPPER: begin
                    if (i_mapper == cbam_pkg::MAP_MBC1) begin
                        if (i_state.mode_16_8) begin
                            nxt.ram_bank = 2'd0;
                            nxt.rom_bank = {1'b0, v[1:0], i_state.rom_bank[4:0]};
                        end else begin
                            nxt.ram_bank = v[1:0];
                        end
                    end else if (i_mapper == cbam_pkg::MAP_MBC3) begin
                        if (v[7:2] == 6'd0) begin
                            nxt.ram_bank = v[1:0];
                        end
                    end
                end
                default: begin
                    if (i_mapper == cbam_pkg::MAP_MBC1) begin
                        if (v[0]) begin
                            nxt.ram_bank  = 2'd0;
                            nxt.mode_16_8 = 1'b0;
                        end else begin
                            nxt.mode_16_8 = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // Cartridge address, masked to the configured width.
    assign raw_cart = addr[14] ? {i_state.rom_bank, addr[13:0]} : {8'd0, addr[13:0]};

    always_comb begin
        for (int i = 0; i < cbam_pkg::CART_OUT_BITS; i++) begin
            cart[i] = (i < EFF_BITS) ? raw_cart[i] : 1'b0;
        end
    end

    // Region decode.
    always_comb begin
        o_res.cart_address = 21'd0;
        o_res.local_offset = addr[12:0];
        if (!addr[15]) begin
            if (i_req.func) begin
                o_res.region = cbam_pkg::RGN_CTRL;
            end else begin
                o_res.region       = addr[14] ? cbam_pkg::RGN_ROMX : cbam_pkg::RGN_ROM0;
                o_res.cart_address = cart;
            end
        end else if (addr[15:13] == 3'b100) begin
            o_res.region = cbam_pkg::RGN_VRAM;
        end else if (addr[15:13] == 3'b101) begin
            o_res.region = cbam_pkg::RGN_ERAM;
        end else if (addr[15:9] != 7'h7F) begin
            o_res.region = cbam_pkg::RGN_WRAM;
        end else if (addr < cbam_pkg::OAM_END) begin
            o_res.region       = cbam_pkg::RGN_OAM;
            o_res.local_offset = {5'd0, addr[7:0]};
        end else if (!addr[8]) begin
            o_res.region       = cbam_pkg::RGN_UNUSABLE;
            o_res.local_offset = {5'd0, addr[7:0]};
        end else if (addr <= cbam_pkg::IO_LAST) begin
            o_res.region       = cbam_pkg::RGN_IO;
            o_res.local_offset = {5'd0, addr[7:0]};
        end else if (addr <= cbam_pkg::HRAM_LAST) begin
            o_res.region       = cbam_pkg::RGN_HRAM;
            o_res.local_offset = {6'd0, addr[6:0]};
        end else begin
            o_res.region       = cbam_pkg::RGN_IE;
            o_res.local_offset = 13'd0;
        end
        o_res.ext_ram_bank    = nxt.ram_bank;
        o_res.ext_ram_enabled = nxt.ram_enable;
    end

    assign o_state = nxt;

endmodule

>>> sv/cartridge_bank_address_map_core.sv
// Top level of the cartridge bank address map: request/result streams and APB register.
`timescale 1ns / 1ps
// Path: a request accepted into the input register moves on into the result register, which drives m_axis.
// Throughput: one request per cycle unless m_axis stalls; the input register and the result
// register form two slots, so a new request is taken while a finished result waits on m_axis.
// Reset (i_rst_n low, synchronous): both slots empty, mapper none, ROM bank 1, RAM bank 0,
// RAM disabled, 16/8 mode.

module cartridge_bank_address_map_core #(
    parameter int CART_ADDR_BITS = cbam_pkg::CART_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] func, [16:1] bus_address, [24:17] write_value, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] region, [24:4] cart_address, [37:25] local_offset,
    // [39:38] ext_ram_bank, [40] ext_ram_enabled, [47:41] zero
    output logic [47:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Mapper select register.
    cbam_pkg::t_mapper     r_mapper;

    // Bank controller state.
    cbam_pkg::t_bank_state r_state;
    cbam_pkg::t_bank_state n_state;

    // Input slot.
    logic                  r_in_valid;
    cbam_pkg::t_request    r_in;

    // Result slot.
    logic                  r_out_valid;
    cbam_pkg::t_result     r_out;
    cbam_pkg::t_result     n_out;

    logic                  in_take;
    logic                  advance;
    logic                  cfg_wr;

    // Move the held request into the result slot when that slot is free or draining.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == cbam_pkg::CFG_MAPPER);
    assign prdata = (paddr[2] == cbam_pkg::CFG_MAPPER) ? {30'd0, r_mapper} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper <= cbam_pkg::MAP_NONE;
        end else if (cfg_wr) begin
            r_mapper <= cbam_pkg::t_mapper'(pwdata[1:0]);
        end
    end

    // Input slot: capture on accept, drop once passed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func        <= s_axis_tdata[0];
            r_in.bus_address <= s_axis_tdata[16:1];
            r_in.write_value <= s_axis_tdata[24:17];
        end
    end

    // Decode and bank update for the held request; state advances with the request,
    // so requests see bank changes strictly in arrival order.
    cbam_map #(
        .CART_ADDR_BITS (CART_ADDR_BITS)
    ) u_map (
        .i_mapper (r_mapper),
        .i_state  (r_state),
        .i_req    (r_in),
        .o_state  (n_state),
        .o_res    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbam_pkg::BANK_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result slot: load on advance, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.ext_ram_enabled, r_out.ext_ram_bank,
                            r_out.local_offset, r_out.cart_address, r_out.region};

endmodule

>>> sv/cbam_checker.sv
// Port-level checks for the cartridge bank address map, bound to the top level.
`timescale 1ns / 1ps

module cbam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Region code stays within the defined set.
    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= cbam_pkg::RGN_CTRL)
        else $error("region code out of range");

    // Cartridge address is zero outside the ROM regions.
    a_cart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] != cbam_pkg::RGN_ROM0
            && m_axis_tdata[3:0] != cbam_pkg::RGN_ROMX
            |-> m_axis_tdata[24:4] == 21'd0)
        else $error("cart address set outside ROM");

    // Request side is ready whenever the result side drains.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("request stalled while result side ready");

endmodule

bind cartridge_bank_address_map_core cbam_checker u_cbam_checker (.*);

>>> sim/cartridge_bank_address_map_core_tb.sv
// Self-checking testbench for the cartridge bank address map core.
`timescale 1ns / 1ps

module cartridge_bank_address_map_core_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned REPORT_CAP  = 100;
    localparam int unsigned RANDOM_PER_PHASE = 219;
    // The mapper register is word 0 of the register file.
    localparam logic [2:0] MAPPER_ADDR = {cbam_pkg::CFG_MAPPER, 2'b00};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] func, [16:1] bus_address, [24:17] write_value, [31:25] zero
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] region, [24:4] cart_address, [37:25] local_offset,
    // [39:38] ext_ram_bank, [40] ext_ram_enabled, [47:41] zero
    logic [47:0] m_axis_tdata;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    cartridge_bank_address_map_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Predictor copy of the bank controller, advanced on every accepted request.
    cbam_pkg::t_mapper     mapper = cbam_pkg::MAP_NONE;
    cbam_pkg::t_bank_state bank   = cbam_pkg::BANK_RESET;

    cbam_pkg::t_request pending_accesses[$];   // requests not yet offered to the block
    cbam_pkg::t_result  expected_maps[$];      // predicted results, oldest first
    cbam_pkg::t_request held;                  // request currently on s_axis

    logic        request_taken = 1'b0;
    int unsigned send_gap = 0, send_gap_pct = 0;
    int unsigned take_stall = 0, take_stall_pct = 0;
    int unsigned cycles = 0, mismatches = 0, reported = 0;
    int unsigned accepted = 0, control_writes = 0, results_checked = 0, settings_run = 0;

    // Map one access: decode its region and offset and apply any bank control write.
    function automatic cbam_pkg::t_result map_access(input cbam_pkg::t_request req);
        cbam_pkg::t_result res;
        logic [15:0]       a;
        logic [7:0]        v;
        logic [21:0]       banked;
        cbam_pkg::t_area   area;
        a    = req.bus_address;
        v    = req.write_value;
        area = cbam_pkg::t_area'(a[14:13]);
        res  = '0;
        res.local_offset = a[12:0];
        if (a < 16'h8000) begin
            if (req.func) begin
                res.region = cbam_pkg::RGN_CTRL;
                // Bank control write; no mapper means nothing changes.
                if (mapper != cbam_pkg::MAP_NONE) begin
                    case (area)
                        cbam_pkg::AREA_RAM_EN: begin
                            // MBC2 only listens with address bit 8 clear.
                            if (!(mapper == cbam_pkg::MAP_MBC2 && a[8]))
                                bank.ram_enable = (v[3:0] == cbam_pkg::RAM_EN_KEY);
                        end
                        cbam_pkg::AREA_ROM_LO: begin
                            if (mapper == cbam_pkg::MAP_MBC1) begin
                                // Low five bits only, bank zero reads as one.
                                bank.rom_bank[4:0] = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
                            end else if (mapper == cbam_pkg::MAP_MBC2) begin
                                if (a[8])
                                    bank.rom_bank = (v[3:0] == 4'd0) ? 8'd1 : {4'd0, v[3:0]};
                            end else begin
                                bank.rom_bank = (v[6:0] == 7'd0) ? 8'd1 : {1'b0, v[6:0]};
                            end
                        end
                        cbam_pkg::AREA_UPPER: begin
                            if (mapper == cbam_pkg::MAP_MBC1) begin
                                if (bank.mode_16_8) begin
                                    // Upper ROM bits; bit 7 drops.
                                    bank.ram_bank = 2'd0;
                                    bank.rom_bank = {1'b0, v[1:0], bank.rom_bank[4:0]};
                                end else begin
                                    bank.ram_bank = v[1:0];
                                end
                            end else if (mapper == cbam_pkg::MAP_MBC3) begin
                                // RTC selects and anything above 3 leave the bank alone.
                                if (v <= 8'd3)
                                    bank.ram_bank = v[1:0];
                            end
                        end
                        cbam_pkg::AREA_MODE: begin
                            if (mapper == cbam_pkg::MAP_MBC1) begin
                                if (v[0]) begin
                                    bank.ram_bank  = 2'd0;
                                    bank.mode_16_8 = 1'b0;
                                end else begin
                                    bank.mode_16_8 = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (a < 16'h4000) begin
                res.region       = cbam_pkg::RGN_ROM0;
                res.cart_address = {5'd0, a};
            end else begin
                res.region       = cbam_pkg::RGN_ROMX;
                banked           = {bank.rom_bank, a[13:0]};
                res.cart_address = banked[20:0];
            end
        end else if (a < 16'hA000) begin
            res.region = cbam_pkg::RGN_VRAM;
        end else if (a < 16'hC000) begin
            res.region = cbam_pkg::RGN_ERAM;
        end else if (a < 16'hFE00) begin
            res.region = cbam_pkg::RGN_WRAM;
        end else if (a < cbam_pkg::OAM_END) begin
            res.region       = cbam_pkg::RGN_OAM;
            res.local_offset = {5'd0, a[7:0]};
        end else if (a < 16'hFF00) begin
            res.region       = cbam_pkg::RGN_UNUSABLE;
            res.local_offset = {5'd0, a[7:0]};
        end else if (a <= cbam_pkg::IO_LAST) begin
            res.region       = cbam_pkg::RGN_IO;
            res.local_offset = {5'd0, a[7:0]};
        end else if (a <= cbam_pkg::HRAM_LAST) begin
            res.region       = cbam_pkg::RGN_HRAM;
            res.local_offset = {6'd0, a[6:0]};
        end else begin
            res.region       = cbam_pkg::RGN_IE;
            res.local_offset = '0;
        end
        res.ext_ram_bank    = bank.ram_bank;
        res.ext_ram_enabled = bank.ram_enable;
        return res;
    endfunction

    // Mostly bank control writes and ROM reads with values the mappers react to,
    // the rest anywhere on the bus.
    function automatic cbam_pkg::t_request random_access();
        cbam_pkg::t_request r;
        int unsigned        pick;
        pick          = $urandom_range(0, 99);
        r.func        = 1'b0;
        r.bus_address = 16'($urandom);
        r.write_value = 8'($urandom);
        if (pick < 45) begin
            r.func = 1'b1;
            r.bus_address[15] = 1'b0;
            case ($urandom_range(0, 6))
                0: r.write_value[3:0] = cbam_pkg::RAM_EN_KEY;
                1: r.write_value = 8'($urandom_range(0, 3));
                2: r.write_value = 8'($urandom_range(8, 12));
                3: r.write_value = 8'h00;
                4: r.write_value[4:0] = 5'd0;
                default: ;
            endcase
        end else if (pick < 75) begin
            r.bus_address[15] = 1'b0;
        end else if (pick < 90) begin
            r.func = 1'($urandom);
        end else begin
            // Top page: oam, unusable, io, high ram and interrupt enable.
            r.func = 1'($urandom);
            r.bus_address[15:9] = 7'h7F;
        end
        return r;
    endfunction

    task automatic queue_access(input logic f, input logic [15:0] a, input logic [7:0] v);
        cbam_pkg::t_request r;
        r.func        = f;
        r.bus_address = a;
        r.write_value = v;
        pending_accesses.push_back(r);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (reported < REPORT_CAP) begin
                reported++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            end
        end
    endtask

    // Hold until nothing is queued, on the bus or still owed by the block, looking at
    // rising edges where the driver's outputs are settled; return at a falling edge.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_maps.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the mapper register, then read it back. Called at a falling edge while idle.
    task automatic program_mapper(input cbam_pkg::t_mapper m);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MAPPER_ADDR;
        pwdata  = {30'd0, m};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        mapper = m;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        check_field("mapper readback", {30'd0, m}, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        settings_run++;
    endtask

    // Request driver: advance to the next request once the current one is taken,
    // with random gaps between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || request_taken) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0
                         && $urandom_range(0, 99) < send_gap_pct) begin
                send_gap      <= $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                held = pending_accesses.pop_front();
                s_axis_tdata  <= {7'd0, held.write_value, held.bus_address, held.func};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall    <= take_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < take_stall_pct) begin
            take_stall    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check the result taken at this edge against the oldest prediction,
    // then predict the request taken at this edge.
    always @(posedge i_clk) begin
        cbam_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_maps.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request owed, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end else begin
                want = expected_maps.pop_front();
                results_checked++;
                check_field("region", 32'(want.region), 32'(m_axis_tdata[3:0]));
                check_field("cart_address", 32'(want.cart_address),
                            32'(m_axis_tdata[24:4]));
                check_field("local_offset", 32'(want.local_offset),
                            32'(m_axis_tdata[37:25]));
                check_field("ext_ram_bank", 32'(want.ext_ram_bank),
                            32'(m_axis_tdata[39:38]));
                check_field("ext_ram_enabled", 32'(want.ext_ram_enabled),
                            32'(m_axis_tdata[40]));
            end
        end
        request_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (request_taken) begin
            accepted++;
            if (held.func && !held.bus_address[15])
                control_writes++;
            expected_maps.push_back(map_access(held));
        end
    end

    // Drop the run if it stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still owed",
                     $time, cycles, expected_maps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cbam_pkg::t_mapper plan [8];
        logic [15:0]       region_limits [15];
        plan = '{cbam_pkg::MAP_MBC1, cbam_pkg::MAP_MBC2, cbam_pkg::MAP_MBC3,
                 cbam_pkg::MAP_NONE, cbam_pkg::MAP_MBC3, cbam_pkg::MAP_MBC1,
                 cbam_pkg::MAP_MBC2, cbam_pkg::MAP_MBC1};
        region_limits = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000,
                          16'hA000, 16'hC000, 16'hFDFF, 16'hFE00, 16'hFEA0,
                          16'hFF00, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF};

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Region edges under reset state, and control writes with no mapper.
        foreach (region_limits[k])
            queue_access(1'b0, region_limits[k], 8'hFF);
        queue_access(1'b1, 16'h2000, 8'h00);

        for (int p = 0; p < 8; p++) begin
            // Drain completely before touching the register.
            wait_drained();
            program_mapper(plan[p]);
            // Leave the last phase free of gaps and stalls.
            send_gap_pct   = (p == 7) ? 0 : $urandom_range(0, 30);
            take_stall_pct = (p == 7) ? 0 : $urandom_range(0, 30);
            case (p)
                0: begin
                    // Bank zero reads as one; upper bits in 16/8 mode; mode switch.
                    queue_access(1'b1, 16'h2000, 8'h00);
                    queue_access(1'b1, 16'h4000, 8'h03);
                    queue_access(1'b0, 16'h7FFF, 8'h00);
                    queue_access(1'b1, 16'h6000, 8'h01);
                    queue_access(1'b1, 16'h5FFF, 8'h02);
                    queue_access(1'b1, 16'h7FFF, 8'h00);
                end
                1: begin
                    // Address bit 8 steers ROM bank and RAM enable writes.
                    queue_access(1'b1, 16'h2100, 8'h00);
                    queue_access(1'b1, 16'h2000, 8'h05);
                    queue_access(1'b1, 16'h0100, 8'h0A);
                end
                2: begin
                    // RTC select is ignored; bank zero reads as one.
                    queue_access(1'b1, 16'h4000, 8'h08);
                    queue_access(1'b1, 16'h2000, 8'h80);
                    queue_access(1'b1, 16'h4000, 8'h03);
                end
                default: ;
            endcase
            repeat (RANDOM_PER_PHASE)
                pending_accesses.push_back(random_access());
        end

        wait_drained();
        // Allow for a late, unexpected result.
        repeat (6) @(posedge i_clk);
        $display("Covered %0d accesses, %0d of them bank control writes, over %0d mapper settings.",
                 accepted, control_writes, settings_run);
        $display("Checked %0d results, %0d mismatching fields.", results_checked, mismatches);
        if (mismatches == 0 && expected_maps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/cbam_pkg.sv
sv/cbam_map.sv
sv/cartridge_bank_address_map_core.sv
sv/cbam_checker.sv
sim/cartridge_bank_address_map_core_tb.sv
